// ===== rtl/sbt_pkg.sv =====
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared types, constants and helper functions for the SDRAM bank timing model.
// ----------------------------------------------------------------------------
package sbt_pkg;

	// fixed field widths
	localparam int ACT_W      = 2;
	localparam int TIME_W     = 48;
	localparam int EXT_W      = 50;
	localparam int ADDR_W     = 33;
	localparam int SIZE_W     = 9;
	localparam int LAT_W      = 32;
	localparam int CYC_W      = 12;
	localparam int INTV_W     = 24;
	localparam int RATIO_W    = 6;
	localparam int CHUNK_W    = 10;
	localparam int DL_W       = 16;
	localparam int LC_W       = 17;
	localparam int PAIR_W     = 13;
	localparam int PAGE_BITS  = 12;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	// item actions
	typedef enum logic [ACT_W-1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_TICK  = 2'd2
	} action_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RAS      = 4'd0,
		CFG_RCD      = 4'd1,
		CFG_CAS      = 4'd2,
		CFG_WR       = 4'd3,
		CFG_RP       = 4'd4,
		CFG_INTERVAL = 4'd5,
		CFG_RATIO    = 4'd6,
		CFG_DDR      = 4'd7
	} cfg_idx_t;

	// controller to datapath commands, one per sequencer step
	typedef struct packed {
		logic load;
		logic lookup;
		logic select;
		logic sum;
		logic merge;
		logic finish;
		logic commit;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic skip;
	} dp_sts_t;

	// floor of log2, for elaboration constants (shift kept below the sign bit)
	function automatic int flog2(input int v);
		int r;
		r = 0;
		for (int i = 0; i < 30; i++) begin
			if (v >= (1 << (i + 1)))
				r = i + 1;
		end
		return r;
	endfunction

	// clamp an extended time to the largest stored time
	function automatic logic [TIME_W-1:0] sat_time(input logic [EXT_W-1:0] v);
		return (|v[EXT_W-1:TIME_W]) ? {TIME_W{1'b1}} : v[TIME_W-1:0];
	endfunction

endpackage

// ===== rtl/sbt_ram.sv =====
// ----------------------------------------------------------------------------
// sbt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/sbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbt_ctrl
// Sequencer for the bank timing datapath: accepts one transaction, steps it
// through lookup and the time arithmetic, and holds the result handshake.
// ----------------------------------------------------------------------------
module sbt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output sbt_pkg::ctrl_cmd_t cmd,
	input  sbt_pkg::dp_sts_t   sts
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_LOOKUP = 7'b0000010,
		ST_SELECT = 7'b0000100,
		ST_SUM    = 7'b0001000,
		ST_MERGE  = 7'b0010000,
		ST_FINISH = 7'b0100000,
		ST_COMMIT = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_LOOKUP;
			end
			ST_LOOKUP: state_d = ST_SELECT;
			ST_SELECT: begin
				if (sts.skip)
					state_d = ST_COMMIT;
				else
					state_d = ST_SUM;
			end
			ST_SUM:    state_d = ST_MERGE;
			ST_MERGE:  state_d = ST_FINISH;
			ST_FINISH: state_d = ST_COMMIT;
			ST_COMMIT: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// step commands
	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.lookup = (state_q == ST_LOOKUP);
		cmd.select = (state_q == ST_SELECT);
		cmd.sum    = (state_q == ST_SUM);
		cmd.merge  = (state_q == ST_MERGE);
		cmd.finish = (state_q == ST_FINISH);
		cmd.commit = (state_q == ST_COMMIT) && slot_free;
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// accepted transaction always starts with a lookup
	a_accept_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_LOOKUP)
		else $error("accepted transaction did not start a lookup");

	// a new result only comes out of the commit step
	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_COMMIT))
		else $error("result raised outside commit");

	// skipped transactions bypass the arithmetic
	a_skip_path: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SELECT && sts.skip |=> state_q == ST_COMMIT)
		else $error("skipped transaction entered the arithmetic steps");

	// a commit always leaves a result waiting
	a_commit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit did not present a result");

endmodule

// ===== rtl/sbt_dpath.sv =====
// ----------------------------------------------------------------------------
// sbt_dpath
// Bank timing datapath: configuration registers, bus and refresh state, the
// per-bank row/precharge RAM and the time arithmetic, one step per command.
// ----------------------------------------------------------------------------
module sbt_dpath #(
	parameter int RANKS     = 2,
	parameter int BANKS     = 8,
	parameter int BUS_BYTES = 8,
	parameter int ADDR_BITS = 33
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sbt_pkg::ctrl_cmd_t                 cmd,
	output sbt_pkg::dp_sts_t                   sts,
	input  logic [sbt_pkg::ACT_W-1:0]          action,
	input  logic [sbt_pkg::TIME_W-1:0]         now,
	input  logic [sbt_pkg::ADDR_W-1:0]         address,
	input  logic [sbt_pkg::SIZE_W-1:0]         size_bytes,
	input  logic                               cfg_valid,
	input  logic [sbt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sbt_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic [sbt_pkg::LAT_W-1:0]          latency,
	output logic                               row_hit,
	output logic                               refresh_issued
);

	localparam int TW      = sbt_pkg::TIME_W;
	localparam int XW      = sbt_pkg::EXT_W;
	localparam int NB      = RANKS * BANKS;
	localparam int IDX_W   = (NB > 1) ? $clog2(NB) : 1;
	localparam int BB      = sbt_pkg::flog2(BANKS);
	localparam int RB      = sbt_pkg::flog2(RANKS);
	localparam int ROW_W   = ADDR_BITS - RB - BB - sbt_pkg::PAGE_BITS;
	localparam int ROW_LSB = sbt_pkg::PAGE_BITS + BB;
	localparam int RNK_LSB = ROW_LSB + ROW_W;
	localparam int LOG_BUS = sbt_pkg::flog2(BUS_BYTES);
	localparam int RKP_W   = (RANKS > 1) ? $clog2(RANKS) : 1;
	localparam int BKP_W   = (BANKS > 1) ? $clog2(BANKS) : 1;
	localparam int ENT_W   = ROW_W + TW;
	localparam logic [63:0] BANK_SEL = (64'd1 << BB) - 64'd1;
	localparam logic [63:0] ROW_SEL  = (64'd1 << ROW_W) - 64'd1;
	localparam logic [63:0] RANK_SEL = (64'd1 << RB) - 64'd1;

	// configuration registers
	logic [sbt_pkg::CYC_W-1:0]   ras_q, rcd_q, cas_q, wr_q, rp_q;
	logic [sbt_pkg::INTV_W-1:0]  intv_q;
	logic [sbt_pkg::RATIO_W-1:0] ratio_q;
	logic                        ddr_q;

	// captured transaction
	logic [sbt_pkg::ACT_W-1:0]  act_q;
	logic [TW-1:0]              now_q;
	logic [sbt_pkg::ADDR_W-1:0] addr_q;
	logic [sbt_pkg::SIZE_W-1:0] size_q;

	// shared bus and refresh state
	logic [TW-1:0]    cbf_q, dbf_q, last_ref_q;
	logic [RKP_W-1:0] rank_ptr_q;
	logic [BKP_W-1:0] bank_ptr_q;
	logic [ROW_W-1:0] row_ptr_q;
	logic [NB-1:0]    valid_q;

	// step registers
	logic [IDX_W-1:0]            idx_q;
	logic [ROW_W-1:0]            row_q;
	logic [TW-1:0]               start_q;
	logic [sbt_pkg::DL_W-1:0]    dl_q;
	logic                        skip_q;
	logic                        hit_q;
	logic [TW-1:0]               pra_old_q;
	logic [TW-1:0]               base_q;
	logic [sbt_pkg::LC_W-1:0]    lc_q;
	logic [XW-1:0]               a_q, x_q, m_q, done_q;

	// output registers
	logic [sbt_pkg::LAT_W-1:0] lat_q;
	logic                      hit_out_q;
	logic                      ref_out_q;

	// decode
	logic is_tick, is_write, is_acc;
	assign is_tick  = (act_q == sbt_pkg::ACT_TICK);
	assign is_write = (act_q == sbt_pkg::ACT_WRITE);
	assign is_acc   = (act_q == sbt_pkg::ACT_READ) || is_write;

	// address split
	logic [63:0]      addr64, bank_v, row_v, rank_v;
	logic [IDX_W-1:0] acc_idx, ref_idx, idx_c;
	logic [ROW_W-1:0] row_c;
	assign addr64  = 64'(addr_q);
	assign bank_v  = (addr64 >> sbt_pkg::PAGE_BITS) & BANK_SEL;
	assign row_v   = (addr64 >> ROW_LSB) & ROW_SEL;
	assign rank_v  = (addr64 >> RNK_LSB) & RANK_SEL;
	assign acc_idx = IDX_W'(32'(rank_v) * 32'(BANKS) + 32'(bank_v));
	assign ref_idx = IDX_W'(32'(rank_ptr_q) * 32'(BANKS) + 32'(bank_ptr_q));
	assign idx_c   = is_tick ? ref_idx : acc_idx;
	assign row_c   = is_tick ? row_ptr_q : ROW_W'(row_v);

	// burst data time
	logic [sbt_pkg::CHUNK_W-1:0] chunks, chunks_sh;
	logic [sbt_pkg::DL_W-1:0]    dl_c;
	assign chunks    = sbt_pkg::CHUNK_W'((11'(size_q) + 11'(BUS_BYTES - 1)) >> LOG_BUS);
	assign chunks_sh = chunks >> ddr_q;
	assign dl_c      = sbt_pkg::DL_W'(chunks_sh) * sbt_pkg::DL_W'(ratio_q);

	// refresh due check on the wrapped difference
	logic [TW-1:0] since_ref;
	logic          due_c, skip_c;
	logic [TW-1:0] start_c;
	assign since_ref = now_q - last_ref_q;
	assign due_c     = (intv_q != '0) && (since_ref >= TW'(intv_q));
	assign skip_c    = !is_acc && !(is_tick && due_c);
	assign start_c   = (cbf_q > now_q) ? cbf_q : now_q;

	// bank entry read back
	logic [ENT_W-1:0] ram_rdata;
	logic [ROW_W-1:0] cur_row;
	logic [TW-1:0]    cur_pra;
	logic             hit_c;
	logic [TW-1:0]    ref_t, base_c;
	logic [sbt_pkg::LC_W-1:0] lc_c;
	assign cur_row = valid_q[idx_q] ? ram_rdata[ENT_W-1:TW] : '0;
	assign cur_pra = valid_q[idx_q] ? ram_rdata[TW-1:0] : '0;
	assign hit_c   = (cur_row == row_q);
	assign ref_t   = is_tick ? now_q : start_q;
	assign base_c  = (!hit_c && (cur_pra > ref_t)) ? cur_pra : ref_t;

	// command-to-done cycles added to the base time
	always_comb begin
		if (is_tick)
			lc_c = hit_c ? '0 : sbt_pkg::LC_W'(cas_q) + sbt_pkg::LC_W'(rcd_q);
		else
			lc_c = sbt_pkg::LC_W'(cas_q) + sbt_pkg::LC_W'(dl_q)
				+ (hit_c ? '0 : sbt_pkg::LC_W'(rcd_q));
	end

	// write-back values
	logic [sbt_pkg::PAIR_W-1:0] wr_rp, ras_rp;
	logic [TW-1:0]              pra_new, cbf_next;
	logic [XW-1:0]              lat_ext;
	logic [sbt_pkg::LAT_W-1:0]  lat_sat;
	logic                       wr_en;
	assign wr_rp  = sbt_pkg::PAIR_W'(wr_q) + sbt_pkg::PAIR_W'(rp_q);
	assign ras_rp = sbt_pkg::PAIR_W'(ras_q) + sbt_pkg::PAIR_W'(rp_q);

	always_comb begin
		if (is_write || is_tick)
			pra_new = sbt_pkg::sat_time(done_q + XW'(wr_rp));
		else if (hit_q)
			pra_new = pra_old_q;
		else
			pra_new = sbt_pkg::sat_time(XW'(base_q) + XW'(ras_rp));
	end

	assign cbf_next = sbt_pkg::sat_time(XW'(cbf_q) + XW'(ratio_q));
	assign lat_ext  = done_q - XW'(now_q);
	assign lat_sat  = (|lat_ext[XW-1:sbt_pkg::LAT_W]) ? '1 : lat_ext[sbt_pkg::LAT_W-1:0];
	assign wr_en    = cmd.commit && !skip_q;

	// per-bank open row and precharge-ready time
	sbt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NB)
	) u_bank_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_q),
		.wdata ({row_q, pra_new}),
		.re    (cmd.lookup),
		.raddr (idx_c),
		.rdata (ram_rdata)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ras_q   <= '0;
			rcd_q   <= '0;
			cas_q   <= '0;
			wr_q    <= '0;
			rp_q    <= '0;
			intv_q  <= '0;
			ratio_q <= sbt_pkg::RATIO_W'(1);
			ddr_q   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				sbt_pkg::CFG_RAS:      ras_q   <= cfg_data[sbt_pkg::CYC_W-1:0];
				sbt_pkg::CFG_RCD:      rcd_q   <= cfg_data[sbt_pkg::CYC_W-1:0];
				sbt_pkg::CFG_CAS:      cas_q   <= cfg_data[sbt_pkg::CYC_W-1:0];
				sbt_pkg::CFG_WR:       wr_q    <= cfg_data[sbt_pkg::CYC_W-1:0];
				sbt_pkg::CFG_RP:       rp_q    <= cfg_data[sbt_pkg::CYC_W-1:0];
				sbt_pkg::CFG_INTERVAL: intv_q  <= cfg_data[sbt_pkg::INTV_W-1:0];
				sbt_pkg::CFG_RATIO:    ratio_q <= cfg_data[sbt_pkg::RATIO_W-1:0];
				sbt_pkg::CFG_DDR:      ddr_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// bus, refresh and valid state, updated at a commit that is not skipped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cbf_q      <= '0;
			dbf_q      <= '0;
			last_ref_q <= '0;
			rank_ptr_q <= '0;
			bank_ptr_q <= '0;
			row_ptr_q  <= '0;
			valid_q    <= '0;
		end else if (wr_en) begin
			valid_q[idx_q] <= 1'b1;
			cbf_q          <= cbf_next;
			if (is_tick) begin
				last_ref_q <= now_q;
				if (rank_ptr_q == RKP_W'(RANKS - 1)) begin
					rank_ptr_q <= '0;
					if (bank_ptr_q == BKP_W'(BANKS - 1)) begin
						bank_ptr_q <= '0;
						row_ptr_q  <= row_ptr_q + ROW_W'(1);
					end else begin
						bank_ptr_q <= bank_ptr_q + BKP_W'(1);
					end
				end else begin
					rank_ptr_q <= rank_ptr_q + RKP_W'(1);
				end
			end else begin
				dbf_q <= sbt_pkg::sat_time(done_q);
			end
		end
	end

	// skip flag is control state read by the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			skip_q <= 1'b0;
		else if (cmd.lookup)
			skip_q <= skip_c;
	end

	// transaction capture and arithmetic steps
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			now_q  <= now;
			addr_q <= address;
			size_q <= size_bytes;
		end
		if (cmd.lookup) begin
			idx_q   <= idx_c;
			row_q   <= row_c;
			start_q <= start_c;
			dl_q    <= dl_c;
		end
		if (cmd.select) begin
			hit_q     <= hit_c;
			pra_old_q <= cur_pra;
			base_q    <= base_c;
			lc_q      <= lc_c;
		end
		if (cmd.sum) begin
			a_q <= XW'(base_q) + XW'(lc_q);
			x_q <= hit_q ? XW'(dbf_q) + XW'(dl_q) : XW'(dbf_q);
		end
		if (cmd.merge)
			m_q <= (is_tick || a_q >= x_q) ? a_q : x_q;
		if (cmd.finish)
			done_q <= (is_tick || hit_q) ? m_q : m_q + XW'(dl_q);
		if (cmd.commit) begin
			lat_q     <= (is_acc && !skip_q) ? lat_sat : '0;
			hit_out_q <= is_acc && hit_q;
			ref_out_q <= is_tick && !skip_q;
		end
	end

	assign sts.skip       = skip_q;
	assign latency        = lat_q;
	assign row_hit        = hit_out_q;
	assign refresh_issued = ref_out_q;

endmodule

// ===== rtl/sdram_bank_timing_model.sv =====
// ----------------------------------------------------------------------------
// sdram_bank_timing_model
// Open-page SDRAM timing model: per-bank open row and precharge tracking,
// shared bus occupancy and round-robin row refresh, one result per item.
// ----------------------------------------------------------------------------
// Steps: after acceptance the sequencer runs lookup, select, sum, merge,
//   finish and commit; a tick with no refresh due or an unused action
//   goes from select straight to commit. One item at a time: a new item is
//   taken only back in idle, and a result left waiting holds the commit step.
// Reset: configuration to defaults (bus clock ratio 1), bus times, refresh
//   pointers and bank valid bits cleared at once; no clearing pass.
module sdram_bank_timing_model #(
	parameter int RANKS     = 2,
	parameter int BANKS     = 8,
	parameter int BUS_BYTES = 8,
	parameter int ADDR_BITS = 33
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sbt_pkg::ACT_W-1:0]      action,
	input  logic [sbt_pkg::TIME_W-1:0]     now,
	input  logic [sbt_pkg::ADDR_W-1:0]     address,
	input  logic [sbt_pkg::SIZE_W-1:0]     size_bytes,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [sbt_pkg::LAT_W-1:0]      latency,
	output logic                           row_hit,
	output logic                           refresh_issued,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sbt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sbt_pkg::CFG_DATA_W-1:0] cfg_data
);

	sbt_pkg::ctrl_cmd_t cmd;
	sbt_pkg::dp_sts_t   sts;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	// sequencer
	sbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// timing datapath
	sbt_dpath #(
		.RANKS     (RANKS),
		.BANKS     (BANKS),
		.BUS_BYTES (BUS_BYTES),
		.ADDR_BITS (ADDR_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.action         (action),
		.now            (now),
		.address        (address),
		.size_bytes     (size_bytes),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.latency        (latency),
		.row_hit        (row_hit),
		.refresh_issued (refresh_issued)
	);

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SDRAM bank timing model. Reads, writes, ticks and
// unused actions go through the valid/ready channels with random bursts and
// output stalls. A bank timing predictor works out latency, row hit and
// refresh for each accepted transaction, and each result is checked in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int ACT_W      = sbt_pkg::ACT_W;
	localparam int TIME_W     = sbt_pkg::TIME_W;
	localparam int ADDR_W     = sbt_pkg::ADDR_W;
	localparam int SIZE_W     = sbt_pkg::SIZE_W;
	localparam int LAT_W      = sbt_pkg::LAT_W;
	localparam int CYC_W      = sbt_pkg::CYC_W;
	localparam int INTV_W     = sbt_pkg::INTV_W;
	localparam int RATIO_W    = sbt_pkg::RATIO_W;
	localparam int CFG_IDX_W  = sbt_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = sbt_pkg::CFG_DATA_W;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int CFG_COUNT    = 8;
	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE_PAUSE = 12;
	localparam int PHASE_ITEMS  = 180;
	localparam logic [TIME_W-1:0] TIME_TOP = {TIME_W{1'b1}};

	typedef struct packed {
		logic [LAT_W-1:0] latency;
		logic             row_hit;
		logic             refresh_issued;
	} timing_result_t;

	typedef struct {
		logic [CYC_W-1:0]   ras, rcd, cas, wr, rp;
		logic [INTV_W-1:0]  interval;
		logic [RATIO_W-1:0] ratio;
		logic               ddr;
	} timing_setting_t;

	typedef enum {READY_ALWAYS, READY_SPARSE_STALL, READY_TOGGLE, READY_HEAVY_STALL}
		ready_mode_t;

	// bank timing predictor and in-order result check
	class sdram_timing_checker;
		logic [CYC_W-1:0]   ras, rcd, cas, wr, rp;
		logic [INTV_W-1:0]  interval;
		logic [RATIO_W-1:0] ratio;
		logic               ddr;
		logic [16:0]        open_row [16];
		logic [TIME_W-1:0]  precharge_at [16];
		logic [TIME_W-1:0]  cmd_free, data_free, prev_refresh_t;
		logic               rank_ptr;
		logic [2:0]         bank_ptr;
		logic [16:0]        row_ptr;
		timing_result_t     pending_timings [$];
		int errors, checked, hits, refreshes, saturated;

		function new();
			ras = '0; rcd = '0; cas = '0; wr = '0; rp = '0;
			interval = '0;
			ratio = 6'd1;
			ddr = 1'b0;
			foreach (open_row[i]) begin
				open_row[i] = '0;
				precharge_at[i] = '0;
			end
			cmd_free = '0; data_free = '0; prev_refresh_t = '0;
			rank_ptr = 1'b0; bank_ptr = '0; row_ptr = '0;
			errors = 0; checked = 0; hits = 0; refreshes = 0; saturated = 0;
		endfunction

		function logic [63:0] later_of(logic [63:0] a, logic [63:0] b);
			return (a > b) ? a : b;
		endfunction

		function logic [TIME_W-1:0] clamp_time(logic [63:0] v);
			return (v > 64'(TIME_TOP)) ? TIME_TOP : v[TIME_W-1:0];
		endfunction

		function int pending();
			return pending_timings.size();
		endfunction

		// register write, out-of-range index ignored
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				sbt_pkg::CFG_RAS:      ras = data[CYC_W-1:0];
				sbt_pkg::CFG_RCD:      rcd = data[CYC_W-1:0];
				sbt_pkg::CFG_CAS:      cas = data[CYC_W-1:0];
				sbt_pkg::CFG_WR:       wr = data[CYC_W-1:0];
				sbt_pkg::CFG_RP:       rp = data[CYC_W-1:0];
				sbt_pkg::CFG_INTERVAL: interval = data[INTV_W-1:0];
				sbt_pkg::CFG_RATIO:    ratio = data[RATIO_W-1:0];
				sbt_pkg::CFG_DDR:      ddr = data[0];
				default: ;
			endcase
		endfunction

		// round-robin row refresh once the interval has elapsed (wrapped difference)
		function bit run_refresh(logic [TIME_W-1:0] t);
			logic [TIME_W-1:0] elapsed;
			logic [3:0]        idx;
			logic [16:0]       row;
			logic [63:0]       done;
			elapsed = t - prev_refresh_t;
			if (interval == '0 || elapsed < TIME_W'(interval))
				return 1'b0;
			idx = {rank_ptr, bank_ptr};
			row = row_ptr;
			rank_ptr = rank_ptr + 1'b1;
			if (rank_ptr == 1'b0) begin
				bank_ptr = bank_ptr + 3'd1;
				if (bank_ptr == 3'd0)
					row_ptr = row_ptr + 17'd1;
			end
			if (open_row[idx] == row) begin
				precharge_at[idx] = clamp_time(64'(t) + wr + rp);
			end else begin
				done = later_of(64'(t), 64'(precharge_at[idx])) + cas + rcd;
				open_row[idx] = row;
				precharge_at[idx] = clamp_time(done + wr + rp);
			end
			cmd_free = clamp_time(64'(cmd_free) + ratio);
			prev_refresh_t = t;
			return 1'b1;
		endfunction

		// accepted input transaction: work out its result
		function void note_item(logic [ACT_W-1:0] act, logic [TIME_W-1:0] t,
			logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] sz);
			timing_result_t r;
			logic [63:0]    start, done, data_time, span, bursts;
			logic [3:0]     idx;
			logic [16:0]    row;
			bit             hit;
			r = '0;
			if (act == sbt_pkg::ACT_TICK) begin
				r.refresh_issued = run_refresh(t);
			end else if (act == sbt_pkg::ACT_READ || act == sbt_pkg::ACT_WRITE) begin
				// 8-byte bus, 12 page bits, 3 bank bits, 17 row bits, 1 rank bit
				bursts = (64'(sz) + 64'd7) >> 3;
				idx = {addr[32], addr[14:12]};
				row = addr[31:15];
				start = later_of(64'(cmd_free), 64'(t));
				data_time = (bursts >> ddr) * 64'(ratio);
				hit = (open_row[idx] == row);
				if (hit) begin
					done = later_of(start + cas + data_time, 64'(data_free) + data_time);
					if (act == sbt_pkg::ACT_WRITE)
						precharge_at[idx] = clamp_time(done + wr + rp);
				end else begin
					start = later_of(start, 64'(precharge_at[idx]));
					done = later_of(start + cas + rcd + data_time, 64'(data_free)) + data_time;
					open_row[idx] = row;
					if (act == sbt_pkg::ACT_WRITE)
						precharge_at[idx] = clamp_time(done + wr + rp);
					else
						precharge_at[idx] = clamp_time(start + ras + rp);
				end
				span = done - 64'(t);
				r.latency = (span > 64'hFFFF_FFFF) ? '1 : span[LAT_W-1:0];
				r.row_hit = hit;
				data_free = clamp_time(done);
				cmd_free = clamp_time(64'(cmd_free) + ratio);
			end
			if (r.row_hit) hits++;
			if (r.refresh_issued) refreshes++;
			if (r.latency == '1) saturated++;
			pending_timings.push_back(r);
		endfunction

		// accepted result transaction: compare with the oldest expectation
		function void check_result(logic [LAT_W-1:0] lat, logic hit, logic refr);
			timing_result_t want;
			if (pending_timings.size() == 0) begin
				$error("result with no transaction outstanding, latency %0d", lat);
				errors++;
				return;
			end
			want = pending_timings.pop_front();
			checked++;
			if (want.latency !== lat) begin
				$error("latency: expected %0d, got %0d", want.latency, lat);
				errors++;
			end
			if (want.row_hit !== hit) begin
				$error("row_hit: expected %0b, got %0b", want.row_hit, hit);
				errors++;
			end
			if (want.refresh_issued !== refr) begin
				$error("refresh_issued: expected %0b, got %0b", want.refresh_issued, refr);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [ACT_W-1:0]      action = '0;
	logic [TIME_W-1:0]     now = '0;
	logic [ADDR_W-1:0]     address = '0;
	logic [SIZE_W-1:0]     size_bytes = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [LAT_W-1:0]      latency;
	logic                  row_hit;
	logic                  refresh_issued;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	sdram_timing_checker chk;
	logic [TIME_W-1:0] cur_t = '0;
	int burst_left = 0;
	int items_sent = 0;
	int settings_applied = 0;
	int cycle_count = 0;
	ready_mode_t ready_mode = READY_ALWAYS;
	int ready_timer = 0;

	sdram_bank_timing_model uut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// receiver stalls, in a pattern picked at random and changed on a timer
	always @(posedge clk) begin
		if (ready_timer == 0) begin
			ready_mode <= ready_mode_t'($urandom_range(0, 3));
			ready_timer <= $urandom_range(20, 120);
		end else begin
			ready_timer <= ready_timer - 1;
		end
		case (ready_mode)
			READY_ALWAYS:       out_ready <= 1'b1;
			READY_SPARSE_STALL: out_ready <= ($urandom_range(0, 3) != 0);
			READY_TOGGLE:       out_ready <= ~out_ready;
			default:            out_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	// transaction monitor: results first, then register writes, then inputs
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				chk.check_result(latency, row_hit, refresh_issued);
			if (cfg_valid && cfg_ready)
				chk.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				chk.note_item(action, now, address, size_bytes);
		end
	end

	function automatic logic [ADDR_W-1:0] make_addr(logic rank, logic [2:0] bank,
		logic [16:0] row);
		return {rank, row, bank, 12'($urandom)};
	endfunction

	// hold one input transaction until accepted; valid stays up for the caller
	task automatic send_item(logic [ACT_W-1:0] act, logic [TIME_W-1:0] t,
		logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] sz);
		in_valid <= 1'b1;
		action <= act;
		now <= t;
		address <= addr;
		size_bytes <= sz;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// every register, junk in the unused upper bits, plus one out-of-range index
	task automatic apply_setting(timing_setting_t s);
		put_reg(sbt_pkg::CFG_RAS, {12'($urandom), s.ras});
		put_reg(sbt_pkg::CFG_RCD, {12'($urandom), s.rcd});
		put_reg(sbt_pkg::CFG_CAS, {12'($urandom), s.cas});
		put_reg(sbt_pkg::CFG_WR, {12'($urandom), s.wr});
		put_reg(sbt_pkg::CFG_RP, {12'($urandom), s.rp});
		put_reg(sbt_pkg::CFG_INTERVAL, s.interval);
		put_reg(sbt_pkg::CFG_RATIO, {18'($urandom), s.ratio});
		put_reg(sbt_pkg::CFG_DDR, {23'($urandom), s.ddr});
		put_reg(CFG_IDX_W'($urandom_range(CFG_COUNT, (1 << CFG_IDX_W) - 1)),
			CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	// wait for every outstanding result, then let the pipeline empty
	task automatic settle(int pause);
		while (chk.pending() != 0) @(posedge clk);
		repeat (pause) @(posedge clk);
	endtask

	function automatic timing_setting_t mid_setting(logic [INTV_W-1:0] intv);
		timing_setting_t s;
		s.ras = CYC_W'($urandom_range(0, 40));
		s.rcd = CYC_W'($urandom_range(0, 40));
		s.cas = CYC_W'($urandom_range(0, 40));
		s.wr = CYC_W'($urandom_range(0, 40));
		s.rp = CYC_W'($urandom_range(0, 40));
		s.interval = intv;
		s.ratio = RATIO_W'($urandom_range(1, 4));
		s.ddr = 1'($urandom);
		return s;
	endfunction

	// random traffic in bursts; rows drawn from a small pool so hits are common
	task automatic drive_traffic(int count, bit wild_time);
		logic [ACT_W-1:0]  act;
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] sz;
		logic [16:0]       row;
		int unsigned       pick;
		for (int n = 0; n < count; n++) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
					: $urandom_range(1, 10);
			end
			pick = $urandom_range(0, 99);
			act = (pick < 45) ? sbt_pkg::ACT_READ : (pick < 80) ? sbt_pkg::ACT_WRITE
				: (pick < 97) ? sbt_pkg::ACT_TICK : ACT_UNUSED;
			// time mostly creeps forward, sometimes leaps or steps back
			pick = $urandom_range(0, 99);
			if (wild_time && pick < 4)
				cur_t = {16'($urandom), 32'($urandom)};
			else if (pick < 4 && cur_t > 48'd2000)
				cur_t = cur_t - 48'($urandom_range(1, 2000));
			else if (pick < 7)
				cur_t = cur_t + 48'($urandom_range(0, 1 << 25));
			else
				cur_t = cur_t + 48'($urandom_range(0, 40));
			pick = $urandom_range(0, 3);
			row = (pick == 3) ? 17'($urandom) : 17'(pick);
			if ($urandom_range(0, 9) == 0)
				addr = {1'($urandom), 32'($urandom)};
			else
				addr = make_addr(1'($urandom), 3'($urandom), row);
			pick = $urandom_range(0, 15);
			sz = (pick == 0) ? 9'd0 : (pick == 1) ? 9'd256 : SIZE_W'($urandom_range(1, 256));
			send_item(act, cur_t, addr, sz);
			burst_left--;
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		timing_setting_t s;
		chk = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: row zero open everywhere, refresh off
		send_item(sbt_pkg::ACT_READ, 48'd0, 33'd0, 9'd8);
		send_item(sbt_pkg::ACT_WRITE, 48'd5, make_addr(1'b1, 3'd3, 17'd5), 9'd256);
		send_item(sbt_pkg::ACT_READ, 48'd6, make_addr(1'b1, 3'd3, 17'd5), 9'd0);
		send_item(ACT_UNUSED, 48'd7, {ADDR_W{1'b1}}, 9'd255);
		send_item(sbt_pkg::ACT_TICK, 48'd8, 33'd0, 9'd0);
		send_item(sbt_pkg::ACT_READ, 48'd9, {ADDR_W{1'b1}}, 9'd1);
		send_item(sbt_pkg::ACT_WRITE, 48'd3, {ADDR_W{1'b1}}, 9'd255);
		in_valid <= 1'b0;
		settle(SETTLE_PAUSE);

		// short refresh interval: due, not due, time stepping back
		s = mid_setting(24'd16);
		apply_setting(s);
		send_item(sbt_pkg::ACT_TICK, 48'd10, 33'd0, 9'd0);
		send_item(sbt_pkg::ACT_TICK, 48'd16, 33'd0, 9'd0);
		send_item(sbt_pkg::ACT_TICK, 48'd17, 33'd0, 9'd0);
		send_item(sbt_pkg::ACT_TICK, 48'd40, 33'd0, 9'd0);
		send_item(sbt_pkg::ACT_TICK, 48'd12, 33'd0, 9'd0);
		send_item(sbt_pkg::ACT_READ, 48'd20, make_addr(1'b0, 3'd0, 17'd0), 9'd100);
		send_item(sbt_pkg::ACT_WRITE, 48'd21, make_addr(1'b0, 3'd0, 17'd1), 9'd7);
		send_item(sbt_pkg::ACT_TICK, 48'd100, 33'd0, 9'd0);
		send_item(sbt_pkg::ACT_READ, 48'd101, make_addr(1'b1, 3'd7, 17'h1FFFF), 9'd256);
		send_item(ACT_UNUSED, 48'd102, 33'd0, 9'd1);
		in_valid <= 1'b0;
		settle(SETTLE_PAUSE);
		cur_t = 48'd200;

		// moderate timings
		apply_setting(mid_setting(24'($urandom_range(8, 120))));
		drive_traffic(PHASE_ITEMS, 1'b0);
		settle(SETTLE_PAUSE);

		// every register at its top value
		s.ras = '1; s.rcd = '1; s.cas = '1; s.wr = '1; s.rp = '1;
		s.interval = '1; s.ratio = '1; s.ddr = 1'b1;
		apply_setting(s);
		cur_t = 48'(chk.later_of(64'(chk.cmd_free), 64'(chk.data_free))) + 48'd64;
		drive_traffic(PHASE_ITEMS, 1'b0);
		settle(SETTLE_PAUSE);

		// all zero, bus clock ratio zero, refresh interval of one
		s.ras = '0; s.rcd = '0; s.cas = '0; s.wr = '0; s.rp = '0;
		s.interval = 24'd1; s.ratio = '0; s.ddr = 1'b0;
		apply_setting(s);
		cur_t = 48'(chk.later_of(64'(chk.cmd_free), 64'(chk.data_free))) + 48'd64;
		drive_traffic(PHASE_ITEMS, 1'b0);
		settle(SETTLE_PAUSE);

		// random values over the full register ranges
		s.ras = CYC_W'($urandom); s.rcd = CYC_W'($urandom); s.cas = CYC_W'($urandom);
		s.wr = CYC_W'($urandom); s.rp = CYC_W'($urandom);
		s.interval = INTV_W'($urandom_range(1, 5000));
		s.ratio = RATIO_W'($urandom_range(1, 63));
		s.ddr = 1'($urandom);
		apply_setting(s);
		cur_t = 48'(chk.later_of(64'(chk.cmd_free), 64'(chk.data_free))) + 48'd64;
		drive_traffic(PHASE_ITEMS, 1'b0);
		settle(SETTLE_PAUSE);

		// refresh disabled
		apply_setting(mid_setting(24'd0));
		cur_t = 48'(chk.later_of(64'(chk.cmd_free), 64'(chk.data_free))) + 48'd64;
		drive_traffic(PHASE_ITEMS, 1'b0);
		settle(SETTLE_PAUSE);

		// time close to the top: saturation, wrap and stray times, kept for last
		apply_setting(mid_setting(24'($urandom_range(8, 200))));
		cur_t = TIME_TOP - 48'd3000;
		drive_traffic(PHASE_ITEMS, 1'b1);

		settle(SETTLE_PAUSE * 2);
		$display("%0d transactions under %0d register settings, %0d results checked",
			items_sent, settings_applied, chk.checked);
		$display("%0d row hits, %0d refreshes, %0d saturated latencies",
			chk.hits, chk.refreshes, chk.saturated);
		if (chk.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
